// File: src/tpc_pkg.sv
// Package for the temperature/pressure compensation core.
// Shared widths, register indexes and the arithmetic shift helper.
package tpc_pkg;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned RawW     = 20;
    localparam int unsigned DivW     = 32;

    localparam logic [CfgIdxW-1:0] RegTempTrim   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegPressTrimA = 2'd1;
    localparam logic [CfgIdxW-1:0] RegPressTrimB = 2'd2;
    localparam logic [CfgIdxW-1:0] RegPressTrimC = 2'd3;

    localparam logic signed [14:0] TempMin  = -15'sd4000;
    localparam logic signed [14:0] TempMax  = 15'sd8500;
    localparam logic [16:0]        PressMax = 17'h1FFFF;

    // One divider lane: valid, partial remainder/quotient, divisor and doubling flag.
    typedef struct packed {
        logic        vld;
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
        logic        big;   // quotient gets doubled at the end
    } t_div_lane;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // arithmetic right shift of a 32-bit word, evaluated on its own
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        asr32 = $signed(v) >>> s;
    endfunction
endpackage

// File: src/tpc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on tpc_pkg. Holds on i_en low.
module tpc_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  tpc_pkg::t_div_lane      i_lane,
    input  logic [31:0]             i_num,
    output tpc_pkg::t_div_lane      o_lane
);
    import tpc_pkg::*;

    t_div_lane   r_lane [DivW];
    logic [31:0] r_num  [DivW];
    t_div_lane   n_lane [DivW];
    logic [31:0] n_num  [DivW];

    always_comb begin
        logic [32:0] trial;
        t_div_lane   src;
        logic [31:0] num;
        for (int s = 0; s < DivW; s++) begin
            src = (s == 0) ? i_lane : r_lane[s-1];
            num = (s == 0) ? i_num  : r_num[s-1];
            trial = {src.rem, num[31]} - {1'b0, src.den};
            n_lane[s] = src;
            n_num[s]  = {num[30:0], 1'b0};
            if (!trial[32]) begin
                n_lane[s].rem = trial[31:0];
                n_lane[s].quo = {src.quo[30:0], 1'b1};
            end else begin
                n_lane[s].rem = {src.rem[30:0], num[31]};
                n_lane[s].quo = {src.quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DivW; s++) r_lane[s].vld <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < DivW; s++) r_lane[s].vld <= n_lane[s].vld;
        end
        if (i_en) begin
            for (int s = 0; s < DivW; s++) begin
                r_lane[s].rem <= n_lane[s].rem;
                r_lane[s].quo <= n_lane[s].quo;
                r_lane[s].den <= n_lane[s].den;
                r_lane[s].big <= n_lane[s].big;
                r_num[s]      <= n_num[s];
            end
        end
    end

    assign o_lane = r_lane[DivW-1];
endmodule

// File: src/temp_press_compensation_core.sv
// Top level of the temperature/pressure compensation core.
// The 32-stage divider between front section and back end sets latency.
// Throughput: one reading pair per cycle unless the output stalls.
// A stall on the output freezes the whole pipeline; the input stays ready
// while the output register is empty or being drained.
// Reset (synchronous, active low) clears valid bits and trim registers to 0.
module temp_press_compensation_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tpc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tpc_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: raw_temp[19:0], raw_press[39:20], zero pad [47:40]
    input  logic [47:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: fine_temp[31:0], temp_centi[46:32], pressure_pa[63:47],
    //        pressure_valid[64], zero pad [71:65]
    output logic [71:0]                  m_axis_tdata
);
    import tpc_pkg::*;

    // trim registers
    logic [47:0] r_ttrim;
    logic [63:0] r_ptrim_a, r_ptrim_b;
    logic [15:0] r_ptrim_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttrim <= '0; r_ptrim_a <= '0; r_ptrim_b <= '0; r_ptrim_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegTempTrim:   r_ttrim   <= i_cfg_data[47:0];
                RegPressTrimA: r_ptrim_a <= i_cfg_data;
                RegPressTrimB: r_ptrim_b <= i_cfg_data;
                RegPressTrimC: r_ptrim_c <= i_cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_ttrim[15:0]};
    assign t2 = sx16(r_ttrim[31:16]);
    assign t3 = sx16(r_ttrim[47:32]);
    assign p1 = {16'd0, r_ptrim_a[15:0]};
    assign p2 = sx16(r_ptrim_a[31:16]);
    assign p3 = sx16(r_ptrim_a[47:32]);
    assign p4 = sx16(r_ptrim_a[63:48]);
    assign p5 = sx16(r_ptrim_b[15:0]);
    assign p6 = sx16(r_ptrim_b[31:16]);
    assign p7 = sx16(r_ptrim_b[47:32]);
    assign p8 = sx16(r_ptrim_b[63:48]);
    assign p9 = sx16(r_ptrim_c);

    // Global stall: everything advances when the output slot is free.
    logic w_en;
    logic r_ovld;
    assign w_en = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage valid bits of the front section (stages 1..9).
    logic [8:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (w_en) r_v <= {r_v[7:0], s_axis_tvalid};
    end

    // Stage 1: capture inputs, temperature differences
    logic [19:0] r1_adcp;
    logic [31:0] r1_x, r1_d;
    // Stage 2: products
    logic [19:0] r2_adcp;
    logic [31:0] r2_a, r2_dd;
    // Stage 3: b term product
    logic [19:0] r3_adcp;
    logic [31:0] r3_a, r3_b;
    // Stage 4: fine
    logic [19:0] r4_adcp;
    logic [31:0] r4_fine, r4_pa;
    // Stage 5: temperature and pressure partials
    logic [19:0] r5_adcp;
    logic [31:0] r5_fine, r5_tc5, r5_q, r5_ap5, r5_ap2;
    // Stage 6
    logic [19:0] r6_adcp;
    logic [31:0] r6_fine, r6_pa_q6, r6_ap5, r6_p3q, r6_ap2;
    logic signed [14:0] r6_tc;
    // Stage 7: r7_a holds p3*(q>>13), r7_ap2 the p2 term
    logic [19:0] r7_adcp;
    logic [31:0] r7_fine, r7_b, r7_a, r7_ap2;
    logic signed [14:0] r7_tc;
    // Stage 8: divisor
    logic [19:0] r8_adcp;
    logic [31:0] r8_fine, r8_b, r8_den_fix;
    logic signed [14:0] r8_tc;
    // Stage 9: dividend
    logic [31:0] r9_fine, r9_num, r9_den;
    logic signed [14:0] r9_tc;

    logic [31:0] w_t5, w_tcs, w_a8b;

    assign w_t5  = r4_fine * 32'd5 + 32'd128;
    assign w_tcs = asr32(r5_tc5, 8);
    assign w_a8b = asr32(asr32(r7_a, 3) + r7_ap2, 18);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_adcp <= s_axis_tdata[39:20];
            r1_x    <= {15'd0, s_axis_tdata[19:3]} - (t1 << 1);
            r1_d    <= {16'd0, s_axis_tdata[19:4]} - t1;

            r2_adcp <= r1_adcp;
            r2_a    <= asr32(r1_x * t2, 11);
            r2_dd   <= asr32(r1_d * r1_d, 12);

            r3_adcp <= r2_adcp;
            r3_a    <= r2_a;
            r3_b    <= asr32(r2_dd * t3, 14);

            r4_adcp <= r3_adcp;
            r4_fine <= r3_a + r3_b;
            r4_pa   <= asr32(r3_a + r3_b, 1) - 32'd64000;

            r5_adcp <= r4_adcp;
            r5_fine <= r4_fine;
            r5_tc5  <= w_t5;
            r5_q    <= asr32(r4_pa, 2) * asr32(r4_pa, 2);
            r5_ap5  <= (r4_pa * p5) << 1;
            r5_ap2  <= r4_pa * p2;

            r6_adcp  <= r5_adcp;
            r6_fine  <= r5_fine;
            if ($signed(w_tcs) < $signed({{17{TempMin[14]}}, TempMin}))
                r6_tc <= TempMin;
            else if ($signed(w_tcs) > $signed({{17{TempMax[14]}}, TempMax}))
                r6_tc <= TempMax;
            else
                r6_tc <= w_tcs[14:0];
            r6_pa_q6 <= asr32(r5_q, 11) * p6;
            r6_ap5   <= r5_ap5;
            r6_p3q   <= p3 * asr32(r5_q, 13);
            r6_ap2   <= asr32(r5_ap2, 1);

            r7_adcp <= r6_adcp;
            r7_fine <= r6_fine;
            r7_tc   <= r6_tc;
            r7_b    <= asr32(r6_pa_q6 + r6_ap5, 2) + (p4 << 16);
            r7_a    <= r6_p3q;
            r7_ap2  <= r6_ap2;

            r8_adcp    <= r7_adcp;
            r8_fine    <= r7_fine;
            r8_tc      <= r7_tc;
            r8_b       <= r7_b;
            r8_den_fix <= asr32((32'd32768 + w_a8b) * p1, 15);

            r9_fine <= r8_fine;
            r9_tc   <= r8_tc;
            r9_den  <= r8_den_fix;
            r9_num  <= ((32'd1048576 - {12'd0, r8_adcp})
                        - asr32(r8_b, 12)) * 32'd3125;
        end
    end

    // Divider. Numerator below 2^31 is pre-doubled; otherwise quotient doubled.
    t_div_lane w_din, w_dout;
    logic [31:0] w_dnum;
    assign w_din.vld = r_v[8];
    assign w_din.rem = '0;
    assign w_din.quo = '0;
    assign w_din.den = r9_den;
    assign w_din.big = r9_num[31];
    assign w_dnum    = r9_num[31] ? r9_num : (r9_num << 1);

    // side data for the divider
    logic [31:0] r_sfine [DivW];
    logic [14:0] r_stc   [DivW];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sfine[0] <= r9_fine;
            r_stc[0]   <= r9_tc;
            for (int s = 1; s < DivW; s++) begin
                r_sfine[s] <= r_sfine[s-1];
                r_stc[s]   <= r_stc[s-1];
            end
        end
    end

    tpc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_lane (w_din),
        .i_num  (w_dnum),
        .o_lane (w_dout)
    );

    // Back end: correction terms (3 stages) and output register.
    logic [31:0] w_p;
    assign w_p = w_dout.big ? {w_dout.quo[30:0], 1'b0} : w_dout.quo;

    logic [2:0]  r_bv;
    logic [31:0] rb1_p, rb1_p8, rb1_fine;
    logic [14:0] rb1_tc;
    logic        rb1_ok;
    logic [31:0] rb2_p, rb2_a, rb2_b, rb2_fine;
    logic [14:0] rb2_tc;
    logic        rb2_ok;
    logic [31:0] rb3_p, rb3_fine;
    logic [14:0] rb3_tc;
    logic        rb3_ok;
    logic [31:0] w_p3sq;
    assign w_p3sq = {3'd0, rb1_p[31:3]} * {3'd0, rb1_p[31:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= '0;
        else if (w_en) r_bv <= {r_bv[1:0], w_dout.vld};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rb1_p    <= w_p;
            rb1_ok   <= (w_dout.den != 32'd0);
            rb1_fine <= r_sfine[DivW-1];
            rb1_tc   <= r_stc[DivW-1];
            rb1_p8   <= asr32({2'd0, w_p[31:2]} * p8, 13);

            rb2_p    <= rb1_p;
            rb2_ok   <= rb1_ok;
            rb2_fine <= rb1_fine;
            rb2_tc   <= rb1_tc;
            rb2_a    <= {13'd0, w_p3sq[31:13]};
            rb2_b    <= rb1_p8;

            rb3_p    <= rb2_p + asr32(asr32(p9 * rb2_a, 12) + rb2_b + p7, 4);
            rb3_ok   <= rb2_ok;
            rb3_fine <= rb2_fine;
            rb3_tc   <= rb2_tc;
        end
    end

    // Output register
    logic [31:0] r_ofine;
    logic [14:0] r_otc;
    logic [16:0] r_opress;
    logic        r_ook;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (w_en) r_ovld <= r_bv[2];
        if (w_en) begin
            r_ofine <= rb3_fine;
            r_otc   <= rb3_tc;
            r_ook   <= rb3_ok;
            if (!rb3_ok || rb3_p[31])        r_opress <= '0;
            else if (rb3_p[30:17] != '0)     r_opress <= PressMax;
            else                             r_opress <= rb3_p[16:0];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {7'd0, r_ook, r_opress, r_otc, r_ofine};

    // Assertions
    a_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[63:47] == '0)
        else $error("invalid pressure not zero");
    a_temp_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[46:32]) >= TempMin) &&
                          ($signed(m_axis_tdata[46:32]) <= TempMax))
        else $error("temperature out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_bv) && $stable(r_v))
        else $error("pipeline moved while stalled");
endmodule

// File: bench/testbench.sv
// Testbench for temp_press_compensation_core: drives raw reading pairs over the
// input stream, predicts each compensated result and checks the output stream.
// Depends on tpc_pkg for register indexes and configuration widths.
module testbench;
    import tpc_pkg::*;

    // the block's register index port is 2 bits, so no index beyond 3 can be sent
    localparam int unsigned PipeLat = 46;

    typedef struct packed {
        logic        press_ok;
        logic [16:0] press_pa;
        logic [14:0] centi;
        logic [31:0] fine;
    } t_comp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [71:0]         m_axis_tdata;

    // local copy of the trim registers
    logic [47:0] trim_t;
    logic [63:0] trim_pa, trim_pb;
    logic [15:0] trim_pc;

    t_comp comp_q[$];
    int    err_cnt = 0;
    int    beats_out = 0;
    bit    hold_off = 1'b0;

    always #5 i_clk = ~i_clk;

    temp_press_compensation_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [31:0] sar(input logic [31:0] v, input int s);
        sar = $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] tw(input logic [63:0] w, input int pos, input bit sgn);
        logic [15:0] f;
        f = w[pos +: 16];
        tw = sgn ? {{16{f[15]}}, f} : {16'h0, f};
    endfunction

    // 32-bit wrapping compensation of one reading pair
    function automatic t_comp compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, p, q, tcw;
        logic signed [31:0] tc;
        t_comp r;
        t1 = tw(trim_t, 0, 0);  t2 = tw(trim_t, 16, 1);  t3 = tw(trim_t, 32, 1);
        p1 = tw(trim_pa, 0, 0); p2 = tw(trim_pa, 16, 1);
        p3 = tw(trim_pa, 32, 1); p4 = tw(trim_pa, 48, 1);
        p5 = tw(trim_pb, 0, 1); p6 = tw(trim_pb, 16, 1);
        p7 = tw(trim_pb, 32, 1); p8 = tw(trim_pb, 48, 1);
        p9 = tw({48'h0, trim_pc}, 0, 1);
        a = sar((({12'h0, rt} >> 3) - (t1 << 1)) * t2, 11);
        d = ({12'h0, rt} >> 4) - t1;
        b = sar(sar(d * d, 12) * t3, 14);
        fine = a + b;
        tcw = sar(fine * 32'd5 + 32'd128, 8);
        tc = $signed(tcw);
        if (tc < -4000) tc = -4000;
        if (tc > 8500) tc = 8500;
        r.fine = fine;
        r.centi = tc[14:0];
        r.press_pa = '0;
        r.press_ok = 1'b0;
        a = sar(fine, 1) - 32'd64000;
        q = sar(a, 2) * sar(a, 2);
        b = sar(q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sar(b, 2) + (p4 << 16);
        a = sar(sar(p3 * sar(q, 13), 3) + sar(p2 * a, 1), 18);
        a = sar((32'd32768 + a) * p1, 15);
        if (a != 0) begin
            p = ((32'd1048576 - {12'h0, rp}) - sar(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else p = (p / a) * 32'd2;
            a = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sar((p >> 2) * p8, 13);
            p = p + sar(a + b + p7, 4);
            if ($signed(p) < 0) r.press_pa = '0;
            else if (p > 32'd131071) r.press_pa = 17'h1FFFF;
            else r.press_pa = p[16:0];
            r.press_ok = 1'b1;
        end
        return r;
    endfunction

    // send one reading pair; prediction is queued at acceptance.
    // valid stays up after the beat so a zero gap gives back-to-back beats.
    task automatic send_pair(input logic [19:0] rt, input logic [19:0] rp);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {8'h0, rp, rt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        comp_q.push_back(compensate(rt, rp));
    endtask

    // send back-to-back without lowering valid between beats
    task automatic send_burst(input int n);
        logic [19:0] rt, rp;
        for (int k = 0; k < n; k++) begin
            rt = 20'($urandom); rp = 20'($urandom);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {8'h0, rp, rt};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            comp_q.push_back(compensate(rt, rp));
        end
    endtask

    // close the input stream and wait for every result
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (comp_q.size() != 0) @(posedge i_clk);
        repeat (PipeLat + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegTempTrim:   trim_t = val[47:0];
            RegPressTrimA: trim_pa = val;
            RegPressTrimB: trim_pb = val;
            default:       trim_pc = val[15:0];
        endcase
        @(posedge i_clk);
    endtask

    // typical datasheet-like trim set
    task automatic load_typical;
        write_reg(RegTempTrim, {16'h0, 16'hFFFF & -16'sd1000, 16'd26435, 16'd27504});
        write_reg(RegPressTrimA, {16'd2855, 16'd3024, 16'hFFFF & -16'sd10685, 16'd36477});
        write_reg(RegPressTrimB, {16'hFFFF & -16'sd12000, 16'd15500,
                                  16'hFFFF & -16'sd7, 16'd140});
        write_reg(RegPressTrimC, 64'd6000);
    endtask

    task automatic load_random;
        write_reg(RegTempTrim, {$urandom, $urandom});
        write_reg(RegPressTrimA, {$urandom, $urandom});
        write_reg(RegPressTrimB, {$urandom, $urandom});
        write_reg(RegPressTrimC, {$urandom, $urandom});
    endtask

    // reset trims: P1 = 0 so every pressure is invalid
    task automatic test_zero_trims;
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair(20'h80000, 20'h7FFFF);
        drain();
    endtask

    task automatic test_directed;
        load_typical();
        send_pair(20'd519888, 20'd415148);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair(20'h55555, 20'hAAAAA);
        send_pair(20'hAAAAA, 20'h55555);
        send_pair(20'd300000, 20'd600000);
        drain();
        // saturation extremes: all-ones and high-bit trims
        write_reg(RegTempTrim, {16'h0, 16'h7FFF, 16'h7FFF, 16'hFFFF});
        write_reg(RegPressTrimA, '1);
        write_reg(RegPressTrimB, {4{16'h8000}});
        write_reg(RegPressTrimC, 64'h8000);
        send_pair('1, '0);
        send_pair('0, '1);
        send_pair(20'h80000, 20'h80000);
        drain();
        write_reg(RegTempTrim, {16'h0, 16'h8000, 16'h8000, 16'h0000});
        write_reg(RegPressTrimA, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
        write_reg(RegPressTrimB, {4{16'h7FFF}});
        write_reg(RegPressTrimC, 64'h7FFF);
        send_pair('1, '1);
        send_pair('0, '0);
        send_pair(20'h12345, 20'hFEDCB);
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            if (ph % 3 == 0) load_typical();
            else load_random();
            // in the third phase of each group of three, the P9 trim gets another random value
            if (ph % 3 == 2) write_reg(RegPressTrimC, {48'h0, 16'($urandom)});
            for (int k = 0; k < per_phase; k++) begin
                if (ph % 3 == 0)
                    send_pair(20'($urandom_range(350000, 650000)),
                              20'($urandom_range(200000, 700000)));
                else
                    send_pair(20'($urandom), 20'($urandom));
            end
            drain();
        end
    endtask

    // receiver stalls long while the sender keeps offering back-to-back beats
    task automatic test_backpressure;
        load_random();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_burst(120);
                drain();
            end
        join
    endtask

    // output side: random stalls, or a long hold-off when asked
    initial begin
        int wait_c;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                wait_c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (wait_c != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_c) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                while (!m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    // result checker, samples at the edge on the handshake
    always @(posedge i_clk) begin
        t_comp want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fine = m_axis_tdata[31:0];
            got.centi = m_axis_tdata[46:32];
            got.press_pa = m_axis_tdata[63:47];
            got.press_ok = m_axis_tdata[64];
            beats_out++;
            if (comp_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = comp_q.pop_front();
                if (got.fine !== want.fine) begin
                    $error("fine_temp exp %h got %h", want.fine, got.fine); err_cnt++;
                end
                if (got.centi !== want.centi) begin
                    $error("temp_centi exp %h got %h", want.centi, got.centi); err_cnt++;
                end
                if (got.press_pa !== want.press_pa) begin
                    $error("pressure_pa exp %h got %h", want.press_pa, got.press_pa);
                    err_cnt++;
                end
                if (got.press_ok !== want.press_ok) begin
                    $error("pressure_valid exp %b got %b", want.press_ok, got.press_ok);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        trim_t = '0; trim_pa = '0; trim_pb = '0; trim_pc = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_trims();
        test_directed();
        test_random(12, 80);
        test_backpressure();
        if (comp_q.size() != 0) begin
            $error("%0d results never arrived", comp_q.size());
            err_cnt++;
        end
        $display("covered reset, typical, extreme and random trims plus a long output stall");
        $display("%0d result beats checked, %0d errors", beats_out, err_cnt);
        if (err_cnt == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
